>>> hdl/angle_bias_kalman_filter_macros.svh
// Assertion macros for the angle/bias Kalman filter checker
`ifndef ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH

// clocked implication with reset disable
`define ABKF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication with reset disable
`define ABKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/abkf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_pkg
// Types and constants for the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package abkf_pkg;

    localparam int DEF_CHANNELS = 2;
    localparam int QW = 32;
    localparam int CW = 31;

    localparam logic [CW-1:0] RST_TIME_STEP     = 31'd1677722;
    localparam logic [CW-1:0] RST_ANGLE_NOISE   = 31'd16777;
    localparam logic [CW-1:0] RST_BIAS_NOISE    = 31'd50332;
    localparam logic [CW-1:0] RST_MEASURE_NOISE = 31'd503316;

    localparam logic [1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // saturate a 34-bit signed value to Q8.24
    function automatic logic signed [QW-1:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return Q_MAX;
        end else if (v < -34'sh0_8000_0000) begin
            return Q_MIN;
        end
        return v[QW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] qadd(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return sat34(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [QW-1:0] qsub(input logic signed [QW-1:0] a,
                                                  input logic signed [QW-1:0] b);
        return sat34(34'(a) - 34'(b));
    endfunction

    // round-half-up scale of a 64-bit product back to Q8.24
    function automatic logic signed [QW-1:0] qscale(input logic signed [63:0] p);
        logic signed [64:0] s;
        logic signed [40:0] q;
        s = 65'(p) + 65'sd8388608;
        q = s[64:24];
        if (q > 41'sh0_7FFF_FFFF) begin
            return Q_MAX;
        end else if (q < -41'sh0_8000_0000) begin
            return Q_MIN;
        end
        return q[QW-1:0];
    endfunction

endpackage

>>> hdl/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state angle/gyro-bias Kalman filter, state in a per-channel memory.
// ----------------------------------------------------------------------------
// channel  | direction | handshake        | payload
// input    | in        | i_valid/o_stall  | channel, measured_angle, gyro_rate
// result   | out       | o_valid/i_stall  | out_channel, angle/bias estimate
// config   | in        | APB              | four 31-bit registers at 4*i
// An item goes through read, five predict multiply steps, two 56-step
// divisions, six update multiply steps (eleven steps, each a multiply and an
// accumulate phase), write and output; the next item is accepted once the block is back in idle.
// Out-of-range channels go straight from read to output.
// Reset clears all channel state through per-channel valid bits.
// A finished result waits in the output register; the next item may be
// accepted while it waits, and its own result stalls until the register frees.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter
    import abkf_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_channel,
    input  logic signed [QW-1:0] i_measured_angle,
    input  logic signed [QW-1:0] i_gyro_rate,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_out_channel,
    output logic signed [QW-1:0] o_angle_estimate,
    output logic signed [QW-1:0] o_bias_estimate
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_WRIT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef struct packed {
        logic signed [QW-1:0] ang;
        logic signed [QW-1:0] bia;
        logic signed [QW-1:0] p00;
        logic signed [QW-1:0] p01;
        logic signed [QW-1:0] p10;
        logic signed [QW-1:0] p11;
    } t_entry;

    t_entry r_mem [CHANNELS];
    t_entry r_rd;
    logic [CHANNELS-1:0] r_vld;

    t_state r_state;
    logic [CW-1:0] r_dt, r_qa, r_qb, r_rn;
    logic [4:0]    r_step;
    logic          r_ch;
    logic          r_inrange;
    logic [AW-1:0] r_addr;
    logic signed [QW-1:0] r_meas, r_rate;
    logic signed [QW-1:0] r_ang, r_bia, r_p00, r_p01, r_p10, r_p11;
    logic signed [QW-1:0] r_s, r_k0, r_k1, r_y, r_o00, r_o01, r_t;
    logic signed [63:0] r_prod;
    logic          r_mphase;
    logic          r_ovalid;
    logic          r_och;
    logic signed [QW-1:0] r_oang, r_obia;
    logic          r_div_start;
    logic          r_div_sel;
    logic          div_done;
    logic signed [QW-1:0] div_q;
    logic signed [QW-1:0] m_a, m_b, mq;
    logic          acc;
    logic          wr;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    always_comb begin
        unique case (paddr[3:2])
            REG_TIME_STEP:   prdata = {1'b0, r_dt};
            REG_ANGLE_NOISE: prdata = {1'b0, r_qa};
            REG_BIAS_NOISE:  prdata = {1'b0, r_qb};
            default:         prdata = {1'b0, r_rn};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= RST_TIME_STEP;
            r_qa <= RST_ANGLE_NOISE;
            r_qb <= RST_BIAS_NOISE;
            r_rn <= RST_MEASURE_NOISE;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                REG_TIME_STEP:   r_dt <= pwdata[CW-1:0];
                REG_ANGLE_NOISE: r_qa <= pwdata[CW-1:0];
                REG_BIAS_NOISE:  r_qb <= pwdata[CW-1:0];
                default:         r_rn <= pwdata[CW-1:0];
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign acc = i_valid & ~o_stall;

    // multiply operand selection per sequencer step
    always_comb begin
        m_a = $signed({1'b0, r_dt});
        m_b = '0;
        unique case (r_step)
            5'd0:  m_b = qsub(r_rate, r_bia);
            5'd1:  m_b = qadd(r_p10, r_p01);
            5'd2:  m_b = $signed({1'b0, r_qa});
            5'd3:  m_b = r_p11;
            5'd4:  m_b = $signed({1'b0, r_qb});
            5'd5:  begin m_a = r_k0; m_b = r_y;   end
            5'd6:  begin m_a = r_k1; m_b = r_y;   end
            5'd7:  begin m_a = r_k0; m_b = r_o00; end
            5'd8:  begin m_a = r_k0; m_b = r_o01; end
            5'd9:  begin m_a = r_k1; m_b = r_o00; end
            5'd10: begin m_a = r_k1; m_b = r_o01; end
            default: m_b = '0;
        endcase
    end
    assign mq = qscale(r_prod);

    abkf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (r_div_sel ? r_p10 : r_p00),
        .i_den  (r_s),
        .o_done (div_done),
        .o_quot (div_q)
    );

    // state memory: one synchronous read per item, one write per in-range item
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd <= r_mem[AW'(i_channel)];
        end
        if (r_state == S_WRIT && r_inrange) begin
            r_mem[r_addr] <= '{r_ang, r_bia, r_p00, r_p01, r_p10, r_p11};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_ovalid    <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            // start the first division after the predict steps, the second
            // right after the first finishes
            r_div_start <= ((r_state == S_MUL) && r_mphase && (r_step == 5'd4)) ||
                           ((r_state == S_DIV) && div_done && !r_div_sel);
            if ((r_state == S_OUT) && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_inrange) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    if (r_mphase && r_step == 5'd4) begin
                        r_state <= S_DIV;
                    end else if (r_mphase && r_step == 5'd10) begin
                        r_state <= S_WRIT;
                    end
                end
                S_DIV: begin
                    if (div_done && r_div_sel) begin
                        r_state <= S_MUL;
                    end
                end
                S_WRIT: begin
                    r_vld[r_addr] <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ch      <= i_channel;
            r_addr    <= AW'(i_channel);
            r_inrange <= ({31'd0, i_channel} < 32'(CHANNELS));
            r_meas    <= i_measured_angle;
            r_rate    <= i_gyro_rate;
            r_step    <= '0;
            r_mphase  <= 1'b0;
            r_div_sel <= 1'b0;
        end
        unique case (r_state)
            S_READ: begin
                if (r_vld[r_addr]) begin
                    r_ang <= r_rd.ang; r_bia <= r_rd.bia;
                    r_p00 <= r_rd.p00; r_p01 <= r_rd.p01;
                    r_p10 <= r_rd.p10; r_p11 <= r_rd.p11;
                end else begin
                    r_ang <= '0; r_bia <= '0; r_p00 <= '0;
                    r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
                end
            end
            S_MUL: begin
                r_mphase <= ~r_mphase;
                if (!r_mphase) begin
                    r_prod <= m_a * m_b;
                end else begin
                    r_step <= r_step + 5'd1;
                    unique case (r_step)
                        5'd0: r_ang <= qadd(r_ang, mq);
                        5'd1: r_p00 <= qsub(r_p00, mq);
                        5'd2: r_p00 <= qadd(r_p00, mq);
                        5'd3: begin
                            r_p01 <= qsub(r_p01, mq);
                            r_p10 <= qsub(r_p10, mq);
                        end
                        5'd4: begin
                            r_p11 <= qadd(r_p11, mq);
                            r_s   <= qadd(r_p00, $signed({1'b0, r_rn}));
                        end
                        5'd5: r_t   <= qadd(r_ang, mq);
                        5'd6: begin
                            r_bia <= qadd(r_bia, mq);
                            r_ang <= r_t;
                        end
                        5'd7: r_p00 <= qsub(r_o00, mq);
                        5'd8: r_p01 <= qsub(r_o01, mq);
                        5'd9: r_p10 <= qsub(r_p10, mq);
                        5'd10: r_p11 <= qsub(r_p11, mq);
                        default: r_t <= r_t;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_div_sel <= 1'b1;
                    if (!r_div_sel) begin
                        r_k0 <= div_q;
                    end else begin
                        r_k1  <= div_q;
                        r_y   <= qsub(r_meas, r_ang);
                        r_o00 <= r_p00;
                        r_o01 <= r_p01;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    r_och  <= r_ch;
                    r_oang <= r_inrange ? r_ang : '0;
                    r_obia <= r_inrange ? r_bia : '0;
                end
            end
            default: r_t <= r_t;
        endcase
    end

    assign o_valid          = r_ovalid;
    assign o_out_channel    = r_och;
    assign o_angle_estimate = r_oang;
    assign o_bias_estimate  = r_obia;
endmodule

>>> hdl/abkf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_div
// Radix-2 restoring divider: saturate((a * 2^24) / b), truncated toward zero.
// ----------------------------------------------------------------------------
module abkf_div
    import abkf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [QW-1:0] i_num,
    input  logic signed [QW-1:0] i_den,
    output logic                 o_done,
    output logic signed [QW-1:0] o_quot
);
    localparam int NW = 56;

    logic [NW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;
    logic [NW-1:0] r_num, n_num;
    logic [QW-1:0] r_den;
    logic          r_neg;
    logic          r_zero;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [NW:0]   w_trial;
    logic [NW-1:0] w_mag;

    always_comb begin
        n_rem   = {r_rem[NW-2:0], r_num[NW-1]};
        n_num   = {r_num[NW-2:0], 1'b0};
        w_trial = {1'b0, n_rem} - {{(NW-QW+1){1'b0}}, r_den};
        if (!w_trial[NW]) begin
            n_rem = w_trial[NW-1:0];
            n_quo = {r_quo[NW-2:0], 1'b1};
        end else begin
            n_quo = {r_quo[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {(i_num[QW-1] ? 32'(-i_num) : 32'(i_num)), 24'd0};
            r_den  <= i_den[QW-1] ? 32'(-i_den) : 32'(i_den);
            r_neg  <= i_num[QW-1] ^ i_den[QW-1];
            r_zero <= (i_den == '0);
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign w_mag = r_quo;
    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (!r_neg) begin
            o_quot = (|w_mag[NW-1:31]) ? Q_MAX : 32'(w_mag[30:0]);
        end else begin
            o_quot = (w_mag > 56'h8000_0000) ? Q_MIN : 32'(-w_mag[31:0]);
        end
    end
    assign o_done = r_done;
endmodule

>>> hdl/abkf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abkf_checker
// Port-level checks for the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
`include "angle_bias_kalman_filter_macros.svh"
module abkf_checker
    import abkf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_out_channel,
    input logic signed [QW-1:0] o_angle_estimate,
    input logic                 pready
);
    `ABKF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_angle_estimate) && $stable(o_out_channel), "stalled result changed")
    `ABKF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "accepted item did not make block busy")
    `ABKF_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready, "pready low")
    `ABKF_ASSERT_NEXT(a_no_result_early, i_clk, i_rst_n, i_valid && !o_stall && !o_valid, !o_valid, "result came with no work")
endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_out_channel   (o_out_channel),
    .o_angle_estimate(o_angle_estimate),
    .pready          (pready)
);
